FILE: src/set_assoc_cache_fifo_hit_counter_assert.svh
// Assertion macros shared by the cache modules.
// Each macro checks one implication at the rising edge of clk, with the
// check switched off while rst_n is low.
`ifndef SET_ASSOC_CACHE_FIFO_HIT_COUNTER_ASSERT_SVH
`define SET_ASSOC_CACHE_FIFO_HIT_COUNTER_ASSERT_SVH

// The consequence must hold in the same cycle as the condition.
`define SAC_ASSERT_SAME(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("sac: same-cycle check failed");

// The consequence must hold in the cycle after the condition.
`define SAC_ASSERT_NEXT(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("sac: next-cycle check failed");

`endif

FILE: src/sac_pkg.sv
`timescale 1ns / 1ps

package sac_pkg;

  localparam int ADDR_W    = 31;
  localparam int CNT_W     = 32;
  localparam int OUT_IDX_W = 2;
  localparam int DEF_SETS  = 4;
  localparam int DEF_WAYS  = 4;
  // Wide enough for any way number up to sixteen ways.
  localparam int MAX_WAY_W = 4;

  // Lookup response from the tag store to the top level.
  typedef struct packed {
    logic                 hit;
    logic [MAX_WAY_W-1:0] way;
  } tag_rsp_t;

endpackage

FILE: src/set_assoc_cache_fifo_hit_counter.sv
`timescale 1ns / 1ps

// Set-associative tag store with FIFO fill and saturating hit/miss totals.
// Each transaction on the in_ channel carries one 31-bit address. The address
// is compared with every stored word in all sets; on a miss it is written into
// set (address mod SETS) at that set's fill pointer, which then advances and
// wraps after the last way, so the oldest entry of the set is replaced.
// Each input transaction yields exactly one out_ transaction carrying the hit
// flag, the set index, the way filled (zero on a hit) and both running totals.
// The input register holds the address and its quotient by SETS, found by
// multiplying with a reciprocal of SETS; the lookup and tag update run on it
// and land in the output register. Throughput is one transaction per cycle
// while out_stall is low; all SETS x WAYS entries are compared combinationally.
// When the receiver raises out_stall the output register holds its result,
// the input register may still fill, and in_stall rises once both are full.
// Synchronous reset (rst_n low) clears all tags and fill pointers to zero,
// clears both totals and empties both registers. Since there are no valid
// bits, address zero hits on a cleared entry right after reset.

`include "set_assoc_cache_fifo_hit_counter_assert.svh"

module set_assoc_cache_fifo_hit_counter #(
  parameter int SETS = sac_pkg::DEF_SETS,
  parameter int WAYS = sac_pkg::DEF_WAYS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sac_pkg::ADDR_W-1:0]    in_address,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_hit,
  output logic [sac_pkg::OUT_IDX_W-1:0] out_set_index,
  output logic [sac_pkg::OUT_IDX_W-1:0] out_way_written,
  output logic [sac_pkg::CNT_W-1:0]     out_hit_total,
  output logic [sac_pkg::CNT_W-1:0]     out_miss_total
);

  localparam int SET_W  = $clog2(SETS);
  localparam int IDX_W  = (SET_W > sac_pkg::OUT_IDX_W) ? SET_W : sac_pkg::OUT_IDX_W;
  // Reciprocal of SETS, exact for every 31-bit address:
  // quotient = (address * RECIP) >> SHIFT.
  localparam int SHIFT   = sac_pkg::ADDR_W + SET_W;
  localparam int RECIP_W = sac_pkg::ADDR_W + 1;
  localparam int PROD_W  = sac_pkg::ADDR_W + RECIP_W;
  localparam longint unsigned RECIP_VAL =
    ((64'd1 << SHIFT) + 64'(SETS) - 64'd1) / 64'(SETS);
  localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'(RECIP_VAL);
  localparam logic [SET_W-1:0]   SETS_LO = SET_W'(SETS);

  // Input register.
  logic                       s1_valid_r;
  logic [sac_pkg::ADDR_W-1:0] s1_addr_r;
  logic [SET_W-1:0]           s1_quo_r;

  // Output register and running totals.
  logic                          out_valid_r;
  logic                          out_hit_r;
  logic [sac_pkg::OUT_IDX_W-1:0] out_set_r;
  logic [sac_pkg::OUT_IDX_W-1:0] out_way_r;
  logic [sac_pkg::CNT_W-1:0]     hit_cnt_r;
  logic [sac_pkg::CNT_W-1:0]     miss_cnt_r;

  logic                      in_fire;
  logic                      proc_fire;
  logic                      s1_valid_nxt;
  logic [PROD_W-1:0]         prod;
  logic [PROD_W-1:0]         quo_full;
  logic [SET_W-1:0]          quo_times_sets;
  logic [SET_W-1:0]          set_idx;
  logic [IDX_W-1:0]          set_ext;
  sac_pkg::tag_rsp_t         rsp;
  logic [sac_pkg::CNT_W-1:0] hit_cnt_nxt;
  logic [sac_pkg::CNT_W-1:0] miss_cnt_nxt;

  // The lookup runs whenever the input register holds a transaction and the
  // output register is empty or is being emptied this cycle.
  assign proc_fire    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall     = s1_valid_r && !proc_fire;
  assign in_fire      = in_valid && !in_stall;
  assign s1_valid_nxt = in_fire || (s1_valid_r && !proc_fire);

  // Only the low bits of the quotient are kept; the remainder is below SETS,
  // so it is recovered exactly modulo 2^SET_W.
  assign prod     = PROD_W'(in_address) * PROD_W'(RECIP);
  assign quo_full = prod >> SHIFT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_addr_r <= in_address;
      s1_quo_r  <= quo_full[SET_W-1:0];
    end
  end

  assign quo_times_sets = s1_quo_r * SETS_LO;
  assign set_idx        = s1_addr_r[SET_W-1:0] - quo_times_sets;
  assign set_ext        = IDX_W'(set_idx);

  sac_tag_store #(
    .SETS (SETS),
    .WAYS (WAYS)
  ) u_tag_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .lookup_en (proc_fire),
    .addr      (s1_addr_r),
    .set_idx   (set_idx),
    .rsp       (rsp)
  );

  // Saturating totals: a counter at its maximum stays there.
  assign hit_cnt_nxt  = (&hit_cnt_r)  ? hit_cnt_r  : hit_cnt_r  + 1'b1;
  assign miss_cnt_nxt = (&miss_cnt_r) ? miss_cnt_r : miss_cnt_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
    end else begin
      if (proc_fire) begin
        out_valid_r <= 1'b1;
        if (rsp.hit) begin
          hit_cnt_r <= hit_cnt_nxt;
        end else begin
          miss_cnt_r <= miss_cnt_nxt;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire) begin
      out_hit_r <= rsp.hit;
      out_set_r <= set_ext[sac_pkg::OUT_IDX_W-1:0];
      out_way_r <= rsp.way[sac_pkg::OUT_IDX_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_set_index   = out_set_r;
  assign out_way_written = out_way_r;
  assign out_hit_total   = hit_cnt_r;
  assign out_miss_total  = miss_cnt_r;

  `SAC_ASSERT_SAME(a_stall_only_when_full, in_stall, s1_valid_r && out_valid_r)
  `SAC_ASSERT_NEXT(a_hit_keeps_miss_total, rst_n && proc_fire && rsp.hit,
                   miss_cnt_r == $past(miss_cnt_r))
  `SAC_ASSERT_NEXT(a_miss_keeps_hit_total, rst_n && proc_fire && !rsp.hit,
                   hit_cnt_r == $past(hit_cnt_r))
  `SAC_ASSERT_SAME(a_set_in_range, s1_valid_r, set_idx <= SET_W'(SETS - 1))

endmodule

FILE: src/sac_tag_store.sv
`timescale 1ns / 1ps

`include "set_assoc_cache_fifo_hit_counter_assert.svh"

module sac_tag_store #(
  parameter int SETS = sac_pkg::DEF_SETS,
  parameter int WAYS = sac_pkg::DEF_WAYS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      lookup_en,
  input  logic [sac_pkg::ADDR_W-1:0] addr,
  input  logic [$clog2(SETS)-1:0]   set_idx,
  output sac_pkg::tag_rsp_t         rsp
);

  localparam int WAY_W = $clog2(WAYS);

  logic [sac_pkg::ADDR_W-1:0] tag_r [SETS][WAYS];
  logic [WAY_W-1:0]           ptr_r [SETS];

  logic             match;
  logic [WAY_W-1:0] cur_ptr;
  logic [WAY_W-1:0] ptr_nxt;

  // Every stored word is compared, in every set.
  always_comb begin
    match = 1'b0;
    for (int s = 0; s < SETS; s++) begin
      for (int w = 0; w < WAYS; w++) begin
        if (tag_r[s][w] == addr) begin
          match = 1'b1;
        end
      end
    end
  end

  assign cur_ptr = ptr_r[set_idx];
  assign ptr_nxt = (cur_ptr == WAY_W'(WAYS - 1)) ? '0 : cur_ptr + 1'b1;

  assign rsp.hit = match;
  assign rsp.way = match ? '0 : sac_pkg::MAX_WAY_W'(cur_ptr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SETS; s++) begin
        ptr_r[s] <= '0;
        for (int w = 0; w < WAYS; w++) begin
          tag_r[s][w] <= '0;
        end
      end
    end else if (lookup_en && !match) begin
      tag_r[set_idx][cur_ptr] <= addr;
      ptr_r[set_idx]          <= ptr_nxt;
    end
  end

  `SAC_ASSERT_SAME(a_ptr_in_range, lookup_en, cur_ptr <= WAY_W'(WAYS - 1))
  `SAC_ASSERT_SAME(a_way_zero_on_hit, lookup_en && match, rsp.way == '0)
  `SAC_ASSERT_NEXT(a_miss_stored, rst_n && lookup_en && !match,
                   tag_r[$past(set_idx)][$past(cur_ptr)] == $past(addr))

endmodule

FILE: tb/set_assoc_cache_fifo_hit_counter_tb.sv
`timescale 1ns / 1ps

module set_assoc_cache_fifo_hit_counter_tb;

  localparam int N_SETS          = 4;
  localparam int N_WAYS          = 4;
  localparam int RANDOM_ACCESSES = 650;
  localparam int MAX_GAP         = 12;
  localparam int RECENT_DEPTH    = 24;
  // The long receiver hold-off and the back-to-back burst that runs into it.
  localparam int HOLD_START      = 300;
  localparam int BURST_LEN       = 40;
  localparam int LONG_HOLD       = 90;
  // Cycles waited past the last owed result before the final check.
  localparam int DRAIN_CYCLES    = 12;
  localparam int TIMEOUT_NS      = 500000;

  // One result as the block presents it, in port order.
  typedef struct packed {
    logic                          hit;
    logic [sac_pkg::OUT_IDX_W-1:0] set_index;
    logic [sac_pkg::OUT_IDX_W-1:0] way_written;
    logic [sac_pkg::CNT_W-1:0]     hit_total;
    logic [sac_pkg::CNT_W-1:0]     miss_total;
  } lookup_t;

  // Mirrors the cache state and keeps the results still owed by the block.
  class lookup_tracker;
    bit [sac_pkg::ADDR_W-1:0] tag_copy [N_SETS*N_WAYS];
    int unsigned              fill_next [N_SETS];
    bit [sac_pkg::CNT_W-1:0]  hits;
    bit [sac_pkg::CNT_W-1:0]  misses;
    lookup_t                  expected_lookups [$];
    int                       mismatches;
    int                       checked;

    function new();
      foreach (tag_copy[i]) tag_copy[i] = '0;
      foreach (fill_next[i]) fill_next[i] = 0;
      hits = '0;
      misses = '0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void note_access(bit [sac_pkg::ADDR_W-1:0] addr);
      lookup_t     want;
      int unsigned set_no;
      int unsigned way_no;
      bit          found;
      set_no = addr % N_SETS;
      way_no = 0;
      found  = 1'b0;
      // The match runs over every set, and several matches are one hit.
      foreach (tag_copy[i]) begin
        if (tag_copy[i] == addr) found = 1'b1;
      end
      if (found) begin
        if (hits != '1) hits++;
      end else begin
        if (misses != '1) misses++;
        way_no = fill_next[set_no] % N_WAYS;
        tag_copy[set_no*N_WAYS + way_no] = addr;
        fill_next[set_no] = (way_no + 1) % N_WAYS;
      end
      want.hit         = found;
      want.set_index   = set_no[sac_pkg::OUT_IDX_W-1:0];
      want.way_written = way_no[sac_pkg::OUT_IDX_W-1:0];
      want.hit_total   = hits;
      want.miss_total  = misses;
      expected_lookups.push_back(want);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(lookup_t got);
      lookup_t want;
      if (expected_lookups.size() == 0) begin
        report_mismatch("result with no access waiting for it");
        return;
      end
      want = expected_lookups.pop_front();
      checked++;
      if (got.hit !== want.hit)
        report_mismatch($sformatf("result %0d hit %b, want %b", checked, got.hit, want.hit));
      if (got.set_index !== want.set_index)
        report_mismatch($sformatf("result %0d set %0d, want %0d", checked,
                                  got.set_index, want.set_index));
      if (got.way_written !== want.way_written)
        report_mismatch($sformatf("result %0d way %0d, want %0d", checked,
                                  got.way_written, want.way_written));
      if (got.hit_total !== want.hit_total)
        report_mismatch($sformatf("result %0d hit total %0d, want %0d", checked,
                                  got.hit_total, want.hit_total));
      if (got.miss_total !== want.miss_total)
        report_mismatch($sformatf("result %0d miss total %0d, want %0d", checked,
                                  got.miss_total, want.miss_total));
    endtask
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [sac_pkg::ADDR_W-1:0]    in_address;
  logic                          out_valid;
  logic                          out_stall;
  logic                          out_hit;
  logic [sac_pkg::OUT_IDX_W-1:0] out_set_index;
  logic [sac_pkg::OUT_IDX_W-1:0] out_way_written;
  logic [sac_pkg::CNT_W-1:0]     out_hit_total;
  logic [sac_pkg::CNT_W-1:0]     out_miss_total;

  lookup_tracker              tracker = new();
  // Addresses accepted lately; drawing from them is what produces hits.
  logic [sac_pkg::ADDR_W-1:0] recent_addrs [$];
  bit                         long_hold_req = 1'b0;
  int                         long_holds = 0;
  int                         backpressure_cycles = 0;

  set_assoc_cache_fifo_hit_counter #(
    .SETS(N_SETS),
    .WAYS(N_WAYS)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_address     (in_address),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_set_index  (out_set_index),
    .out_way_written(out_way_written),
    .out_hit_total  (out_hit_total),
    .out_miss_total (out_miss_total)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offers one address after an idle gap and holds it until the block takes
  // it. The valid stays high across back-to-back transactions, so it is only
  // lowered when a gap actually follows.
  task send_access(input logic [sac_pkg::ADDR_W-1:0] addr, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_address <= addr;
    do @(posedge clk); while (in_stall);
    tracker.note_access(addr);
    recent_addrs.push_back(addr);
    if (recent_addrs.size() > RECENT_DEPTH) void'(recent_addrs.pop_front());
  endtask

  // Every handshake on the result side goes to the tracker. Values are taken
  // at the clock edge, before the block's own updates of that edge land.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_result({out_hit, out_set_index, out_way_written,
                            out_hit_total, out_miss_total});
    if (rst_n && in_valid && in_stall)
      backpressure_cycles++;
  end

  // Receiver: before each result it stalls a random number of cycles, or not
  // at all during calm stretches. Once the stimulus asks for it, it stalls for
  // a long stretch so that the block fills up and pushes back on its input.
  initial begin : result_sink
    int hold_cycles;
    int taken;
    bit calm;
    taken = 0;
    calm  = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (taken % 40 == 0) calm = ($urandom_range(0, 2) == 0);
      if (long_hold_req) begin
        hold_cycles   = LONG_HOLD;
        long_hold_req = 1'b0;
        long_holds++;
      end else if (calm) begin
        hold_cycles = 0;
      end else begin
        hold_cycles = $urandom_range(0, MAX_GAP);
      end
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      taken++;
    end
  end

  initial begin : stimulus
    logic [sac_pkg::ADDR_W-1:0] directed_addrs [$];
    logic [sac_pkg::ADDR_W-1:0] addr;
    int                         pick;
    int                         gap;
    bit                         calm;

    in_valid   <= 1'b0;
    in_address <= '0;
    out_stall  <= 1'b0;
    rst_n      <= 1'b0;
    calm = 1'b0;

    // Directed opening. Address zero hits on the cleared entries, which all
    // match at once and still count as one hit. The all-ones address and the
    // two alternating patterns take every address bit both ways. Set 2 then
    // gets five misses, so its pointer wraps and the oldest entry goes; the
    // evicted address misses again, and an address still held hits. Last,
    // set 0 is filled with new tags, and zero must still hit on the cleared
    // entries left in the other sets.
    directed_addrs = '{31'h0000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                       31'h5555_5555, 31'h2AAA_AAAA,
                       31'd2, 31'd6, 31'd10, 31'd14, 31'd18, 31'd2, 31'd10,
                       31'd4, 31'd8, 31'd12, 31'd16, 31'h0000_0000,
                       31'h4000_0000, 31'd1, 31'h5555_5555};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_addrs[i])
      send_access(directed_addrs[i], (i % 3 == 0) ? $urandom_range(0, 4) : 0);

    // Random part. Half the addresses repeat recent ones, so hits and FIFO
    // replacement both happen often; small addresses churn the few sets, and
    // full-width ones keep every address bit moving.
    for (int n = 0; n < RANDOM_ACCESSES; n++) begin
      if (n % 50 == 0) calm = ($urandom_range(0, 2) == 0);
      if (n == HOLD_START) long_hold_req = 1'b1;
      pick = $urandom_range(0, 9);
      if (pick < 5 && recent_addrs.size() > 0)
        addr = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
      else if (pick < 8)
        addr = sac_pkg::ADDR_W'($urandom_range(0, 63));
      else
        addr = sac_pkg::ADDR_W'($urandom());
      // The burst after the hold request keeps offering back to back.
      if (calm || (n >= HOLD_START && n < HOLD_START + BURST_LEN))
        gap = 0;
      else
        gap = $urandom_range(0, MAX_GAP);
      send_access(addr, gap);
    end
    in_valid <= 1'b0;

    while (tracker.expected_lookups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.expected_lookups.size() != 0)
      tracker.report_mismatch("results still owed at the end of the run");

    $display("Checked %0d lookups: %0d hits and %0d misses, FIFO wrap in every set.",
             tracker.checked, tracker.hits, tracker.misses);
    $display("Receiver held off %0d long stretch(es); input was pushed back for %0d cycles.",
             long_holds, backpressure_cycles);
    if (tracker.mismatches == 0)
      $display("set_assoc_cache_fifo_hit_counter regression: pass");
    else
      $display("set_assoc_cache_fifo_hit_counter regression: fail");
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Run timed out with %0d results outstanding.",
             tracker.expected_lookups.size());
    $display("set_assoc_cache_fifo_hit_counter regression: fail");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/sac_pkg.sv
src/sac_tag_store.sv
src/set_assoc_cache_fifo_hit_counter.sv
tb/set_assoc_cache_fifo_hit_counter_tb.sv
